>>> rtl/kfc_pkg.sv
// Shared types and key codes for the keypad four-function calculator.
package kfc_pkg;

  // Key kinds carried on the op field
  localparam logic [1:0] OP_OPER  = 2'd0;
  localparam logic [1:0] OP_DIGIT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // ASCII operator codes, held at the width of the pending operation
  localparam logic [7:0] KEY_MUL = 8'd42;
  localparam logic [7:0] KEY_ADD = 8'd43;
  localparam logic [7:0] KEY_SUB = 8'd45;
  localparam logic [7:0] KEY_DIV = 8'd47;
  localparam logic [7:0] KEY_EQU = 8'd61;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CNT_W  = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_WAIT,
    ST_RESP
  } kfc_state_t;

  // Request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic              start;
    logic [7:0]        opc;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  // Response from the arithmetic unit
  typedef struct packed {
    logic              done;
    logic              err;
    logic [DATA_W-1:0] y;
  } alu_rsp_t;

endpackage

>>> rtl/kfc_alu.sv
// Iterative arithmetic unit: shift-add multiply, restoring divide, add and subtract.
module kfc_alu (
  input  logic              clk,
  input  logic              rst,
  input  kfc_pkg::alu_req_t req,
  output kfc_pkg::alu_rsp_t rsp
);

  localparam int unsigned W = kfc_pkg::DATA_W;

  logic                        busy;
  logic                        is_div;
  logic                        neg_q;
  logic [kfc_pkg::CNT_W-1:0]   cnt;
  logic [W-1:0]                acc;
  logic [W-1:0]                mq;
  logic [W-1:0]                mcand;
  logic                        done;
  logic                        err;
  logic [W-1:0]                y;

  // Shared adder operands
  logic [W:0]   add_x;
  logic [W:0]   add_y;
  logic         add_cin;
  logic [W+1:0] sum;
  logic [W:0]   sh;
  logic         ge;
  logic [W-1:0] q_fin;
  logic [W-1:0] a_mag;
  logic [W-1:0] b_mag;

  assign sh    = {acc, mq[W-1]};
  assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_cin};
  assign ge    = sum[W+1];
  assign q_fin = {mq[W-2:0], ge};
  assign a_mag = req.a[W-1] ? (~req.a + 1'b1) : req.a;
  assign b_mag = req.b[W-1] ? (~req.b + 1'b1) : req.b;

  // Select the adder inputs for the running or starting operation
  always_comb begin
    priority if (busy && !is_div) begin
      add_x   = {1'b0, acc};
      add_y   = mq[0] ? {1'b0, mcand} : '0;
      add_cin = 1'b0;
    end else if (busy) begin
      add_x   = sh;
      add_y   = ~{1'b0, mcand};
      add_cin = 1'b1;
    end else if (req.opc == kfc_pkg::KEY_SUB) begin
      add_x   = {1'b0, req.a};
      add_y   = ~{1'b0, req.b};
      add_cin = 1'b1;
    end else begin
      add_x   = {1'b0, req.a};
      add_y   = {1'b0, req.b};
      add_cin = 1'b0;
    end
  end

  // Load on start, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      err  <= 1'b0;
      y    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        err <= 1'b0;
        unique case (req.opc)
          kfc_pkg::KEY_MUL: begin
            acc    <= '0;
            mq     <= req.b;
            mcand  <= req.a;
            cnt    <= '1;
            is_div <= 1'b0;
            busy   <= 1'b1;
          end
          kfc_pkg::KEY_DIV: begin
            if (req.b == '0) begin
              y    <= '0;
              err  <= 1'b1;
              done <= 1'b1;
            end else begin
              acc    <= '0;
              mq     <= a_mag;
              mcand  <= b_mag;
              neg_q  <= req.a[W-1] ^ req.b[W-1];
              cnt    <= '1;
              is_div <= 1'b1;
              busy   <= 1'b1;
            end
          end
          kfc_pkg::KEY_ADD, kfc_pkg::KEY_SUB: begin
            y    <= sum[W-1:0];
            done <= 1'b1;
          end
          default: begin
            y    <= '0;
            done <= 1'b1;
          end
        endcase
      end else if (busy) begin
        if (is_div) begin
          acc <= ge ? sum[W-1:0] : sh[W-1:0];
          mq  <= q_fin;
        end else begin
          acc   <= sum[W-1:0];
          mcand <= {mcand[W-2:0], 1'b0};
          mq    <= {1'b0, mq[W-1:1]};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (is_div) begin
            y <= neg_q ? (~q_fin + 1'b1) : q_fin;
          end else begin
            y <= sum[W-1:0];
          end
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.err  = err;
  assign rsp.y    = y;

endmodule

>>> rtl/kfc_ctrl.sv
// Key sequencer: entry state, operand build-up and result register.
module kfc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  output logic              key_stall,
  input  logic [1:0]        op,
  input  logic [6:0]        key,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [15:0]       result,
  output logic              result_ready,
  output logic              divide_error,
  output kfc_pkg::alu_req_t alu_req,
  input  kfc_pkg::alu_rsp_t alu_rsp
);

  localparam int unsigned W = kfc_pkg::DATA_W;

  kfc_pkg::kfc_state_t state;
  kfc_pkg::kfc_state_t state_next;

  logic [W-1:0] first_operand;
  logic [W-1:0] second_operand;
  logic         entering_second;
  logic         first_digits_typed;
  logic         first_negative;
  logic         second_negative;
  logic [7:0]   pending_operation;
  logic [W-1:0] last_result;
  logic [W-1:0] a_eff;
  logic [W-1:0] b_eff;
  logic         ready_flag;
  logic         derr_flag;

  logic         accept;
  logic         is_equals;
  logic [7:0]   key_code;
  logic [W-1:0] cur_operand;
  logic [W-1:0] digit_next;
  logic         alu_start;

  assign accept    = key_valid && !key_stall;
  assign key_code  = {1'b0, key};
  assign is_equals = (op == kfc_pkg::OP_OPER) && (key_code == kfc_pkg::KEY_EQU);

  // Operand times ten plus the key, wrapping on 16 bits
  assign cur_operand = entering_second ? second_operand : first_operand;
  assign digit_next  = {cur_operand[W-4:0], 3'b000} + {cur_operand[W-2:0], 1'b0}
                     + {{(W-7){1'b0}}, key};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      kfc_pkg::ST_IDLE:  if (accept) state_next = is_equals ? kfc_pkg::ST_PREP : kfc_pkg::ST_RESP;
      kfc_pkg::ST_PREP:  state_next = kfc_pkg::ST_START;
      kfc_pkg::ST_START: state_next = kfc_pkg::ST_WAIT;
      kfc_pkg::ST_WAIT:  if (alu_rsp.done) state_next = kfc_pkg::ST_RESP;
      kfc_pkg::ST_RESP:  if (!res_stall) state_next = kfc_pkg::ST_IDLE;
      default:           state_next = kfc_pkg::ST_IDLE;
    endcase
  end

  // Handshake and unit start
  always_comb begin
    key_stall = 1'b1;
    res_valid = 1'b0;
    alu_start = 1'b0;
    unique case (state)
      kfc_pkg::ST_IDLE:  key_stall = 1'b0;
      kfc_pkg::ST_START: alu_start = 1'b1;
      kfc_pkg::ST_RESP:  res_valid = 1'b1;
      default:           key_stall = 1'b1;
    endcase
  end

  assign alu_req.start = alu_start;
  assign alu_req.opc   = pending_operation;
  assign alu_req.a     = a_eff;
  assign alu_req.b     = b_eff;

  // Entry state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= kfc_pkg::ST_IDLE;
      first_operand      <= '0;
      second_operand     <= '0;
      entering_second    <= 1'b0;
      first_digits_typed <= 1'b0;
      first_negative     <= 1'b0;
      second_negative    <= 1'b0;
      pending_operation  <= '0;
      last_result        <= '0;
      ready_flag         <= 1'b0;
      derr_flag          <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        kfc_pkg::ST_IDLE: begin
          if (accept && !is_equals) begin
            ready_flag <= 1'b0;
            derr_flag  <= 1'b0;
            priority if (op == kfc_pkg::OP_OPER) begin
              if (!first_digits_typed) first_operand <= last_result;
              pending_operation <= key_code;
              entering_second   <= 1'b1;
            end else if (op == kfc_pkg::OP_CLEAR) begin
              first_operand      <= '0;
              second_operand     <= '0;
              entering_second    <= 1'b0;
              first_digits_typed <= 1'b0;
              first_negative     <= 1'b0;
              second_negative    <= 1'b0;
              pending_operation  <= '0;
              last_result        <= '0;
            end else if (!entering_second) begin
              first_digits_typed <= 1'b1;
              if (key_code == kfc_pkg::KEY_SUB) first_negative <= 1'b1;
              else first_operand <= digit_next;
            end else begin
              if (key_code == kfc_pkg::KEY_SUB) second_negative <= 1'b1;
              else second_operand <= digit_next;
            end
          end
        end
        kfc_pkg::ST_PREP: begin
          a_eff <= first_negative  ? (~first_operand + 1'b1)  : first_operand;
          b_eff <= second_negative ? (~second_operand + 1'b1) : second_operand;
        end
        kfc_pkg::ST_WAIT: begin
          if (alu_rsp.done) begin
            last_result        <= alu_rsp.y;
            ready_flag         <= 1'b1;
            derr_flag          <= alu_rsp.err;
            first_operand      <= '0;
            second_operand     <= '0;
            entering_second    <= 1'b0;
            first_digits_typed <= 1'b0;
            first_negative     <= 1'b0;
            second_negative    <= 1'b0;
            pending_operation  <= '0;
          end
        end
        default: begin
          ready_flag <= ready_flag;
        end
      endcase
    end
  end

  assign result       = last_result;
  assign result_ready = ready_flag;
  assign divide_error = derr_flag;

endmodule

>>> rtl/keypad_four_function_calculator.sv
// Top level of the keypad four-function calculator.
//
// One key event is taken on the key channel (key_valid, key_stall, op, key)
// and exactly one result leaves on the result channel (res_valid, res_stall,
// result, result_ready, divide_error) for every key transfer.
// The block works on one key at a time: key_stall stays high from the cycle
// after a transfer until its result has been taken.
// Number, operator and clear keys are entered at the transfer, and the
// result is offered in the next cycle.
// An '=' key runs the pending operation on the shared iterative unit:
// multiply and divide step bit by bit through the shift-add or restoring loop;
// add, subtract, unknown operations and division by zero finish at the start.
// Before the unit is started, '=' passes an operand preparation state, and
// the result is offered once the unit reports done.
// While res_stall is high the result holds and no new key is taken.
// Reset (rst, synchronous, active high) zeroes both operands, the entry
// flags, the pending operation and the last result, and empties the
// result channel.
module keypad_four_function_calculator (
  input  logic        clk,
  input  logic        rst,
  input  logic        key_valid,
  output logic        key_stall,
  input  logic [1:0]  op,
  input  logic [6:0]  key,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] result,
  output logic        result_ready,
  output logic        divide_error
);

  kfc_pkg::alu_req_t alu_req;
  kfc_pkg::alu_rsp_t alu_rsp;

  kfc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .op           (op),
    .key          (key),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result       (result),
    .result_ready (result_ready),
    .divide_error (divide_error),
    .alu_req      (alu_req),
    .alu_rsp      (alu_rsp)
  );

  kfc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule

>>> rtl/kfc_checker.sv
// Port-level checks for the calculator, bound to the top level.
module kfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        key_valid,
  input logic        key_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [15:0] result,
  input logic        result_ready,
  input logic        divide_error
);

  // One key at a time: no key is taken while a result waits
  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> key_stall)
    else $error("key taken while a result is pending");

  // A key transfer closes the key channel in the next cycle
  a_stall_after_key: assert property (@(posedge clk) disable iff (rst)
    (key_valid && !key_stall) |=> key_stall)
    else $error("key channel open right after a transfer");

  // A division error is only reported on an '=' result of zero
  a_div_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && divide_error) |-> (result_ready && result == 16'd0))
    else $error("divide error with non-zero or non-equals result");

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(result)))
    else $error("stalled result dropped or changed");

endmodule

bind keypad_four_function_calculator kfc_checker u_kfc_checker (
  .clk          (clk),
  .rst          (rst),
  .key_valid    (key_valid),
  .key_stall    (key_stall),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .result       (result),
  .result_ready (result_ready),
  .divide_error (divide_error)
);
